// ===== rtl/rpt_pkg.sv =====
// shared types, constants and the arctangent table for the pointer tip generator
package rpt_pkg;

    // cordic datapath: signed, unit 2^-30, one guard bit over the worst-case magnitude
    localparam int CORDIC_W      = 33;
    localparam int CORDIC_STAGES = 24;
    localparam int STEP_W        = 16;
    localparam int CFG_IDX_W     = 3;

    typedef logic signed [CORDIC_W-1:0] cordic_t;
    typedef logic [1:0]                 quad_t;

    // cordic start vector x, the inverse gain 0.60725 in q30
    localparam cordic_t X_INIT = 33'sd652032874;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CENTER_X       = 3'd0,
        CFG_CENTER_Y       = 3'd1,
        CFG_POINTER_RADIUS = 3'd2,
        CFG_TURN_STEP      = 3'd3,
        CFG_CCW            = 3'd4
    } cfg_reg_t;

    // atan(2^-stage) in units of 2^-32 turn
    function automatic cordic_t atan_of(input int stage);
        cordic_t a;
        case (stage)
            0:       a = 33'sd536870912;
            1:       a = 33'sd316933406;
            2:       a = 33'sd167458907;
            3:       a = 33'sd85004756;
            4:       a = 33'sd42667331;
            5:       a = 33'sd21354465;
            6:       a = 33'sd10679838;
            7:       a = 33'sd5340245;
            8:       a = 33'sd2670163;
            9:       a = 33'sd1335087;
            10:      a = 33'sd667544;
            11:      a = 33'sd333772;
            12:      a = 33'sd166886;
            13:      a = 33'sd83443;
            14:      a = 33'sd41722;
            15:      a = 33'sd20861;
            16:      a = 33'sd10430;
            17:      a = 33'sd5215;
            18:      a = 33'sd2608;
            19:      a = 33'sd1304;
            20:      a = 33'sd652;
            21:      a = 33'sd326;
            22:      a = 33'sd163;
            23:      a = 33'sd81;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

// ===== rtl/rpt_cordic_cell.sv =====
// one rotation-mode cordic cell of the pipelined chain, with its sideband
module rpt_cordic_cell #(
    parameter int STAGE      = 0,
    parameter int ANGLE_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  en,
    input  logic                  in_valid,
    input  rpt_pkg::quad_t        in_quad,
    input  logic [ANGLE_BITS-1:0] in_angle,
    input  rpt_pkg::cordic_t      in_x,
    input  rpt_pkg::cordic_t      in_y,
    input  rpt_pkg::cordic_t      in_z,
    output logic                  out_valid,
    output rpt_pkg::quad_t        out_quad,
    output logic [ANGLE_BITS-1:0] out_angle,
    output rpt_pkg::cordic_t      out_x,
    output rpt_pkg::cordic_t      out_y,
    output rpt_pkg::cordic_t      out_z
);

    localparam rpt_pkg::cordic_t ATAN = rpt_pkg::atan_of(STAGE);

    logic                  valid_reg;
    rpt_pkg::quad_t        quad_reg;
    logic [ANGLE_BITS-1:0] angle_reg;
    rpt_pkg::cordic_t      x_reg, y_reg, z_reg;
    rpt_pkg::cordic_t      x_next, y_next, z_next;
    rpt_pkg::cordic_t      dx, dy;

    // arithmetic shift on signed values rounds toward minus infinity
    assign dx = in_y >>> STAGE;
    assign dy = in_x >>> STAGE;

    always_comb
    begin
        if (!in_z[rpt_pkg::CORDIC_W-1])
        begin
            x_next = in_x - dx;
            y_next = in_y + dy;
            z_next = in_z - ATAN;
        end
        else
        begin
            x_next = in_x + dx;
            y_next = in_y - dy;
            z_next = in_z + ATAN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quad_reg  <= in_quad;
            angle_reg <= in_angle;
            x_reg     <= x_next;
            y_reg     <= y_next;
            z_reg     <= z_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_quad  = quad_reg;
    assign out_angle = angle_reg;
    assign out_x     = x_reg;
    assign out_y     = y_reg;
    assign out_z     = z_reg;

endmodule

// ===== rtl/rpt_tip_scale.sv =====
// quadrant fold, radius multiply, rounding and center offset, ending in the output register
module rpt_tip_scale #(
    parameter int ANGLE_BITS = 16,
    parameter int FRAC_BITS  = 4,
    parameter int COORD_BITS = 12
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             en,
    input  logic                             in_valid,
    input  rpt_pkg::quad_t                   in_quad,
    input  logic [ANGLE_BITS-1:0]            in_angle,
    input  rpt_pkg::cordic_t                 in_x,
    input  rpt_pkg::cordic_t                 in_y,
    input  logic [COORD_BITS-1:0]            center_x,
    input  logic [COORD_BITS-1:0]            center_y,
    input  logic [COORD_BITS-2:0]            radius,
    output logic                             out_valid,
    output logic [COORD_BITS+FRAC_BITS+1:0]  out_x,
    output logic [COORD_BITS+FRAC_BITS+1:0]  out_y,
    output logic [ANGLE_BITS-1:0]            out_angle
);

    localparam int OUT_W = COORD_BITS + FRAC_BITS + 2;
    localparam int PW    = rpt_pkg::CORDIC_W + COORD_BITS;
    localparam logic signed [PW-1:0] ROUND_HALF = PW'(1) << (29 - FRAC_BITS);

    rpt_pkg::cordic_t              cs, sn;
    logic signed [COORD_BITS-1:0]  radius_s;
    logic signed [PW-1:0]          prod_x_next, prod_y_next;
    logic signed [PW-1:0]          prod_x_reg, prod_y_reg;
    logic [ANGLE_BITS-1:0]         prod_angle_reg;
    logic                          prod_valid_reg;
    logic signed [PW-1:0]          cx_sh, cy_sh, off_x, off_y, sum_x, sum_y;
    logic [OUT_W-1:0]              out_x_reg, out_y_reg;
    logic [ANGLE_BITS-1:0]         out_angle_reg;
    logic                          out_valid_reg;

    // exact quadrant fold by swap and negate
    always_comb
    begin
        case (in_quad)
            2'd0:    begin cs = in_x;  sn = in_y;  end
            2'd1:    begin cs = -in_y; sn = in_x;  end
            2'd2:    begin cs = -in_x; sn = -in_y; end
            default: begin cs = in_y;  sn = -in_x; end
        endcase
    end

    assign radius_s    = $signed({1'b0, radius});
    assign prod_x_next = cs * radius_s;
    assign prod_y_next = sn * radius_s;

    // round half up into 1/2^frac pixel, then add the shifted center
    assign off_x = (prod_x_reg + ROUND_HALF) >>> (30 - FRAC_BITS);
    assign off_y = (prod_y_reg + ROUND_HALF) >>> (30 - FRAC_BITS);
    assign cx_sh = $signed(PW'(center_x) << FRAC_BITS);
    assign cy_sh = $signed(PW'(center_y) << FRAC_BITS);
    assign sum_x = cx_sh + off_x;
    assign sum_y = cy_sh + off_y;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else if (en)
        begin
            prod_valid_reg <= in_valid;
            out_valid_reg  <= prod_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_x_reg     <= prod_x_next;
            prod_y_reg     <= prod_y_next;
            prod_angle_reg <= in_angle;
            out_x_reg      <= sum_x[OUT_W-1:0];
            out_y_reg      <= sum_y[OUT_W-1:0];
            out_angle_reg  <= prod_angle_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_angle = out_angle_reg;

`ifndef SYNTHESIS
    a_out_from_prod: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(prod_valid_reg))
        else $error("output word appeared without a product word behind it");

    a_out_holds_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(out_x_reg) && $stable(out_y_reg) && $stable(prod_valid_reg))
        else $error("scale stage moved while stalled");

    a_radius_zero: assert property (@(posedge clk) disable iff (!rst_n)
        en && prod_valid_reg && prod_x_reg == '0 |=>
            out_x_reg == $past(cx_sh[OUT_W-1:0]))
        else $error("zero offset did not land on the center");
`endif

endmodule

// ===== rtl/rotating_pointer_tip_generator.sv =====
// top level: angle accumulator, cordic cell chain and tip scaling
//
// Each accepted tick word optionally steps the pointer angle (a binary
// fraction of a full turn, reset to three quarters, pointing up) by the
// signed turn_step, negated when counter_clockwise is set, wrapping mod one
// turn, and then yields one result word: the tip at center + radius *
// (cos, sin) of the angle in 1/2^FRAC_BITS pixel, plus the angle itself.
// A new tick is taken every cycle unless the output stalls; the only
// feedback is the single angle adder, and after it come the head register,
// a 24-cell cordic chain, a multiply stage and the output register that
// drives out_valid. When the output word is not taken the whole chain
// holds and in_ready drops in the same cycle. Configuration writes
// take effect at once and must only be issued while the block is empty.
module rotating_pointer_tip_generator #(
    parameter int ANGLE_BITS = 16,
    parameter int FRAC_BITS  = 4,
    parameter int COORD_BITS = 12
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // tick words
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  advance,
    // result words
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [COORD_BITS+FRAC_BITS+1:0] tip_x,
    output logic signed [COORD_BITS+FRAC_BITS+1:0] tip_y,
    output logic [ANGLE_BITS-1:0]                 angle_now,
    // configuration writes
    input  logic                                  cfg_we,
    input  logic [rpt_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [((COORD_BITS > rpt_pkg::STEP_W) ? COORD_BITS : rpt_pkg::STEP_W)-1:0]
                                                  cfg_data
);

    localparam int STAGES = rpt_pkg::CORDIC_STAGES;
    localparam int SW     = (ANGLE_BITS > rpt_pkg::STEP_W) ? ANGLE_BITS : rpt_pkg::STEP_W;
    localparam logic [ANGLE_BITS-1:0] ANGLE_RESET = ANGLE_BITS'(3) << (ANGLE_BITS - 2);

    // configuration registers
    logic [COORD_BITS-1:0]         center_x_reg, center_y_reg;
    logic [COORD_BITS-2:0]         radius_reg;
    logic [rpt_pkg::STEP_W-1:0]    turn_step_reg;
    logic                          ccw_reg;

    // angle accumulator and chain head
    logic [ANGLE_BITS-1:0]         turn_angle_reg, turn_angle_next;
    logic signed [SW-1:0]          step_ext, step_eff;
    logic                          head_valid_reg;
    logic                          accept;
    logic                          adv;
    logic [29:0]                   angle_frac;

    // cell chain taps, index 0 feeds the first cell
    logic                          c_valid [0:STAGES];
    rpt_pkg::quad_t                c_quad  [0:STAGES];
    logic [ANGLE_BITS-1:0]         c_angle [0:STAGES];
    rpt_pkg::cordic_t              c_x     [0:STAGES];
    rpt_pkg::cordic_t              c_y     [0:STAGES];
    rpt_pkg::cordic_t              c_z     [0:STAGES];
    logic [STAGES:0]               valid_vec;

    logic [COORD_BITS+FRAC_BITS+1:0] scale_x, scale_y;

    // whole pipeline moves unless a finished word is waiting
    assign adv      = !out_valid || out_ready;
    assign in_ready = adv;
    assign accept   = in_valid && in_ready;

    // configuration decode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg  <= '0;
            center_y_reg  <= '0;
            radius_reg    <= '0;
            turn_step_reg <= '0;
            ccw_reg       <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                rpt_pkg::CFG_CENTER_X:       center_x_reg  <= cfg_data[COORD_BITS-1:0];
                rpt_pkg::CFG_CENTER_Y:       center_y_reg  <= cfg_data[COORD_BITS-1:0];
                rpt_pkg::CFG_POINTER_RADIUS: radius_reg    <= cfg_data[COORD_BITS-2:0];
                rpt_pkg::CFG_TURN_STEP:      turn_step_reg <= cfg_data[rpt_pkg::STEP_W-1:0];
                rpt_pkg::CFG_CCW:            ccw_reg       <= cfg_data[0];
                default:                     ;
            endcase
        end
    end

    // step sign-extended to the wider of the angle and step widths, negated for counter-clockwise
    assign step_ext = SW'($signed(turn_step_reg));
    assign step_eff = ccw_reg ? -step_ext : step_ext;

    always_comb
    begin
        turn_angle_next = turn_angle_reg;
        if (accept && advance)
            turn_angle_next = turn_angle_reg + step_eff[ANGLE_BITS-1:0];
    end

    // the first cell samples the angle register once head_valid_reg holds the tick and the chain advances;
    // the register cannot move in between because it only moves on acceptance
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            turn_angle_reg <= ANGLE_RESET;
            head_valid_reg <= 1'b0;
        end
        else
        begin
            turn_angle_reg <= turn_angle_next;
            if (adv)
                head_valid_reg <= accept;
        end
    end

    // angle within its quadrant in units of 2^-32 turn; the top two angle bits are the quadrant
    assign angle_frac = {turn_angle_reg[ANGLE_BITS-3:0], (32 - ANGLE_BITS)'(0)};

    assign c_valid[0] = head_valid_reg;
    assign c_quad[0]  = turn_angle_reg[ANGLE_BITS-1 -: 2];
    assign c_angle[0] = turn_angle_reg;
    assign c_x[0]     = rpt_pkg::X_INIT;
    assign c_y[0]     = '0;
    assign c_z[0]     = rpt_pkg::cordic_t'(angle_frac);

    for (genvar i = 0; i < STAGES; i++)
    begin : g_cell
        rpt_cordic_cell #(
            .STAGE      (i),
            .ANGLE_BITS (ANGLE_BITS)
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .in_valid  (c_valid[i]),
            .in_quad   (c_quad[i]),
            .in_angle  (c_angle[i]),
            .in_x      (c_x[i]),
            .in_y      (c_y[i]),
            .in_z      (c_z[i]),
            .out_valid (c_valid[i+1]),
            .out_quad  (c_quad[i+1]),
            .out_angle (c_angle[i+1]),
            .out_x     (c_x[i+1]),
            .out_y     (c_y[i+1]),
            .out_z     (c_z[i+1])
        );
    end

    for (genvar k = 0; k <= STAGES; k++)
    begin : g_vvec
        assign valid_vec[k] = c_valid[k];
    end

    // final residual angle is not needed past the last cell
    rpt_tip_scale #(
        .ANGLE_BITS (ANGLE_BITS),
        .FRAC_BITS  (FRAC_BITS),
        .COORD_BITS (COORD_BITS)
    ) u_scale (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (c_valid[STAGES]),
        .in_quad   (c_quad[STAGES]),
        .in_angle  (c_angle[STAGES]),
        .in_x      (c_x[STAGES]),
        .in_y      (c_y[STAGES]),
        .center_x  (center_x_reg),
        .center_y  (center_y_reg),
        .radius    (radius_reg),
        .out_valid (out_valid),
        .out_x     (scale_x),
        .out_y     (scale_y),
        .out_angle (angle_now)
    );

    assign tip_x = $signed(scale_x);
    assign tip_y = $signed(scale_y);

`ifndef SYNTHESIS
    a_angle_moves_only_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
        turn_angle_reg != $past(turn_angle_reg) |-> $past(accept && advance))
        else $error("pointer angle changed without an advancing tick");

    a_report_tick_keeps_angle: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !advance |=> $stable(turn_angle_reg))
        else $error("report-only tick moved the angle");

    a_chain_frozen_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(valid_vec))
        else $error("cell chain moved while the output was stalled");
`endif

endmodule
